@@ src/mt64_pkg.sv @@
`default_nettype none

package mt64_pkg;

	localparam int MT_STATE_WORDS = 312;
	localparam int MT_MIDDLE_OFFSET = 156;

	localparam logic [31:0] SEED_MULT_HI = 32'h5851_F42D;
	localparam logic [31:0] SEED_MULT_LO = 32'h4C95_7F2D;
	localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] TEMPER_MASK_A = 64'h5555_5555_5555_5555;
	localparam logic [63:0] TEMPER_MASK_B = 64'h71D6_7FFF_EDA6_0000;
	localparam logic [63:0] TEMPER_MASK_C = 64'hFFF7_EEE0_0000_0000;

	localparam logic REQ_RESEED = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_LL,
		S_MUL_LH,
		S_MUL_HL,
		S_SEED_WR,
		S_TW_LD,
		S_TW_RD,
		S_TW_WR,
		S_DRAW_RD,
		S_DRAW_OUT
	} mt_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SEED0,
		OP_MUL_LL,
		OP_MUL_LH,
		OP_MUL_HL,
		OP_SEED_WR,
		OP_TW_PRE,
		OP_TW_LD,
		OP_TW_RD,
		OP_TW_WR,
		OP_DRAW_RD,
		OP_DRAW_OUT
	} mt_op_t;

	typedef struct packed {
		mt_op_t op;
	} mt_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic idx_end;
	} mt_status_t;

endpackage

`default_nettype wire

@@ src/mt64_ctrl.sv @@
`default_nettype none

module mt64_ctrl import mt64_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       req_type,
	input  wire mt_status_t status,
	output mt_cmd_t         cmd,
	output logic            busy
);

	mt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_RESEED) begin
						state_d = S_MUL_LL;
					end else if (status.idx_end) begin
						state_d = S_TW_LD;
					end else begin
						state_d = S_DRAW_OUT;
					end
				end
			end
			S_MUL_LL:   state_d = S_MUL_LH;
			S_MUL_LH:   state_d = S_MUL_HL;
			S_MUL_HL:   state_d = S_SEED_WR;
			S_SEED_WR:  state_d = status.cnt_last ? S_IDLE : S_MUL_LL;
			S_TW_LD:    state_d = S_TW_WR;
			S_TW_RD:    state_d = S_TW_WR;
			S_TW_WR:    state_d = status.cnt_last ? S_DRAW_RD : S_TW_RD;
			S_DRAW_RD:  state_d = S_DRAW_OUT;
			S_DRAW_OUT: state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (req_type == REQ_RESEED) begin
						cmd.op = OP_SEED0;
					end else if (status.idx_end) begin
						cmd.op = OP_TW_PRE;
					end else begin
						cmd.op = OP_DRAW_RD;
					end
				end
			end
			S_MUL_LL:   cmd.op = OP_MUL_LL;
			S_MUL_LH:   cmd.op = OP_MUL_LH;
			S_MUL_HL:   cmd.op = OP_MUL_HL;
			S_SEED_WR:  cmd.op = OP_SEED_WR;
			S_TW_LD:    cmd.op = OP_TW_LD;
			S_TW_RD:    cmd.op = OP_TW_RD;
			S_TW_WR:    cmd.op = OP_TW_WR;
			S_DRAW_RD:  cmd.op = OP_DRAW_RD;
			S_DRAW_OUT: cmd.op = OP_DRAW_OUT;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

@@ src/mt64_dpath.sv @@
`default_nettype none

module mt64_dpath import mt64_pkg::*; #(
	parameter int STATE_WORDS = MT_STATE_WORDS,
	parameter int MIDDLE_OFFSET = MT_MIDDLE_OFFSET
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mt_cmd_t     cmd,
	input  wire logic [63:0] seed_value,
	output mt_status_t       status,
	output logic      [63:0] random_word,
	output logic             done
);

	localparam int AW = $clog2(STATE_WORDS);
	localparam int CW = $clog2(STATE_WORDS + 1);

	function automatic logic [63:0] temper(input logic [63:0] w);
		logic [63:0] v;
		v = w;
		v = v ^ ((v >> 29) & TEMPER_MASK_A);
		v = v ^ ((v << 17) & TEMPER_MASK_B);
		v = v ^ ((v << 37) & TEMPER_MASK_C);
		v = v ^ (v >> 43);
		return v;
	endfunction

	logic [63:0] mem [STATE_WORDS];

	logic [CW-1:0] cnt_q, idx_q;
	logic          done_q;
	logic [63:0]   prev_q, prod_q, lo_q, cur_q, rda_q, rdb_q, word_q;
	logic [31:0]   hi_q;

	logic [CW:0]   nxt_sum, mid_sum;
	logic [AW-1:0] addr_nxt, addr_mid, ra, wa;
	logic          we;
	logic [63:0]   wd, xw, seed_word, twist_y, twist_word, mul_p;
	logic [31:0]   mul_a, mul_b, hi_sum;

	always_comb begin
		nxt_sum = {1'b0, cnt_q} + (CW + 1)'(1);
		mid_sum = {1'b0, cnt_q} + (CW + 1)'(MIDDLE_OFFSET);
		if (nxt_sum >= (CW + 1)'(STATE_WORDS)) begin
			addr_nxt = AW'(nxt_sum - (CW + 1)'(STATE_WORDS));
		end else begin
			addr_nxt = AW'(nxt_sum);
		end
		if (mid_sum >= (CW + 1)'(STATE_WORDS)) begin
			addr_mid = AW'(mid_sum - (CW + 1)'(STATE_WORDS));
		end else begin
			addr_mid = AW'(mid_sum);
		end
	end

	// 64x64 seed multiply, low half only, as three 32x32 partial products
	assign xw = prev_q ^ (prev_q >> 62);
	assign mul_a = (cmd.op == OP_MUL_HL) ? SEED_MULT_HI : SEED_MULT_LO;
	assign mul_b = (cmd.op == OP_MUL_LH) ? xw[63:32] : xw[31:0];
	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};
	assign hi_sum = hi_q + prod_q[31:0];
	assign seed_word = lo_q + {hi_sum, 32'b0} + {{(64 - CW){1'b0}}, cnt_q};

	assign twist_y = {cur_q[63:31], rda_q[30:0]};
	assign twist_word = rdb_q ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 64'b0);

	always_comb begin
		we = 1'b0;
		wa = cnt_q[AW-1:0];
		wd = twist_word;
		ra = addr_nxt;
		unique case (cmd.op)
			OP_SEED0: begin
				we = 1'b1;
				wa = '0;
				wd = seed_value;
			end
			OP_SEED_WR: begin
				we = 1'b1;
				wd = seed_word;
			end
			OP_TW_WR:   we = 1'b1;
			OP_TW_PRE:  ra = '0;
			OP_DRAW_RD: ra = idx_q[AW-1:0];
			default:    we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rda_q <= mem[ra];
		rdb_q <= mem[addr_mid];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= CW'(STATE_WORDS);
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_DRAW_OUT);
			case (cmd.op)
				OP_SEED0: begin
					cnt_q <= CW'(1);
					idx_q <= CW'(STATE_WORDS);
				end
				OP_SEED_WR: cnt_q <= cnt_q + CW'(1);
				OP_TW_PRE:  cnt_q <= '0;
				OP_TW_WR: begin
					cnt_q <= cnt_q + CW'(1);
					idx_q <= '0;
				end
				OP_DRAW_OUT: idx_q <= idx_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SEED0:    prev_q <= seed_value;
			OP_MUL_LL:   prod_q <= mul_p;
			OP_MUL_LH: begin
				lo_q <= prod_q;
				prod_q <= mul_p;
			end
			OP_MUL_HL: begin
				hi_q <= prod_q[31:0];
				prod_q <= mul_p;
			end
			OP_SEED_WR:  prev_q <= seed_word;
			OP_TW_LD:    cur_q <= rda_q;
			OP_TW_WR:    cur_q <= rda_q;
			OP_DRAW_OUT: word_q <= temper(rda_q);
			default: ;
		endcase
	end

	assign status.cnt_last = (cnt_q == CW'(STATE_WORDS - 1));
	assign status.idx_end = (idx_q >= CW'(STATE_WORDS));
	assign random_word = word_q;
	assign done = done_q;

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CW'(STATE_WORDS))
		else $error("read index past end of state");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held two cycles");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SEED_WR || cmd.op == OP_TW_WR) |-> cnt_q < CW'(STATE_WORDS))
		else $error("state write out of range");

	a_draw_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DRAW_OUT) |-> !status.idx_end)
		else $error("draw without regenerated word");
`endif

endmodule

`default_nettype wire

@@ src/mersenne_twister_64_generator_core.sv @@
// Channel   Ports                          Transaction
// request   start, req_type, seed_value    start && !busy at rising clk
// result    done, random_word              done high for one cycle
//
// Draw: the word is read into a register, then tempered into random_word with
// done; a new request may be accepted in the cycle the result is shown.
// Draw needing a twist: a read and a write state per word, one RAM write port.
// Reseed: per word, three 32x32 partial products (MUL_*) and a write state.
// arst_n clears control state; the state RAM is not cleared.
// The receiver cannot stall: done is a strobe with no back-pressure.
`default_nettype none

module mersenne_twister_64_generator_core import mt64_pkg::*; #(
	parameter int STATE_WORDS = MT_STATE_WORDS,
	parameter int MIDDLE_OFFSET = MT_MIDDLE_OFFSET
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic [63:0] seed_value,
	output logic             done,
	output logic      [63:0] random_word
);

	mt_cmd_t    cmd;
	mt_status_t status;

	mt64_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	mt64_dpath #(
		.STATE_WORDS   (STATE_WORDS),
		.MIDDLE_OFFSET (MIDDLE_OFFSET)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_value  (seed_value),
		.status      (status),
		.random_word (random_word),
		.done        (done)
	);

endmodule

`default_nettype wire
